FILE: rtl/core/rlfe_pkg.sv
// Shared types and constants for the RGBW linear fade engine.
// Used by the scaling unit and the top level; depends on nothing else.
package rlfe_pkg;

    // Action codes carried on the input channel
    localparam logic [2:0] ACT_SET_TARGET  = 3'd0;
    localparam logic [2:0] ACT_SET_CURRENT = 3'd1;
    localparam logic [2:0] ACT_START       = 3'd2;
    localparam logic [2:0] ACT_TICK        = 3'd3;
    localparam logic [2:0] ACT_READ        = 3'd4;

    localparam int ACT_W  = 3;
    localparam int IDX_W  = 6;
    localparam int CH_W   = 8;
    localparam int NCH    = 4;
    localparam int CSEL_W = 2;
    localparam int FAC_W  = 6;
    localparam int DIFF_W = 9;
    localparam int PX_W   = NCH * CH_W;
    localparam int DPX_W  = NCH * DIFF_W;

    // One channel handed to the scaling unit
    typedef struct packed {
        logic                     vld;
        logic [FAC_W-1:0]         factor;
        logic signed [DIFF_W-1:0] diff;
        logic [CH_W-1:0]          target;
        logic [CSEL_W-1:0]        ch;
    } scale_req_t;

    // One scaled channel coming back
    typedef struct packed {
        logic              vld;
        logic [CH_W-1:0]   value;
        logic [CSEL_W-1:0] ch;
    } scale_rsp_t;

endpackage

FILE: rtl/core/rgbw_linear_fade_engine_top.sv
// RGBW linear fade engine: target, current and difference frames, sequencer, output stage.
// Depends on rlfe_pkg, rlfe_ram and rlfe_scale_unit.
//
// The engine holds a target and a current frame of PIXELS RGBW pixels. Set
// transfers return nothing. A read presents one result through the RDADDR
// and RDOUT states and the output register. A start or a tick (tick only
// while a fade runs) rewrites and emits the whole frame, one result per
// pixel: each pixel is fetched from the frame RAMs, then its four channels
// pass one after another through the shared three-stage
// multiply-by-reciprocal scaler before the pixel is written back and sent.
// The input is not ready until the last pixel of the run is handed to the
// output register. No input transfer is taken while any item is in progress.
module rgbw_linear_fade_engine_top #(
    parameter int PIXELS = 32,
    parameter int STEPS  = 37
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // pixel_index[5:0], green_in, red_in, blue_in, white_in, 2'b0
    input  logic [2:0]  s_tuser,  // action
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // pixel_out_index[5:0], green_out, red_out, blue_out,
                                  // white_out, 2'b0
    output logic        m_tlast,  // last_pixel
    output logic        m_tuser   // still_fading
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int IDX_W = rlfe_pkg::IDX_W;
    localparam int CH_W  = rlfe_pkg::CH_W;
    localparam int NCH   = rlfe_pkg::NCH;
    localparam int DW    = rlfe_pkg::DIFF_W;
    localparam int PX_W  = rlfe_pkg::PX_W;
    localparam int DPX_W = rlfe_pkg::DPX_W;
    localparam int FAC_W = rlfe_pkg::FAC_W;
    localparam int CSEL_W = rlfe_pkg::CSEL_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_RDADDR = 3'd6;
    localparam logic [2:0] ST_RDOUT  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [FAC_W-1:0]  factor_reg;
    logic [FAC_W-1:0]  pass_f_reg;
    logic              fade_active_reg;
    logic              start_reg;
    logic [CSEL_W-1:0] ch_reg;
    logic [PIXELS-1:0] tgt_vld_reg;
    logic [PIXELS-1:0] cur_vld_reg;
    logic [PX_W-1:0]   tgt_px_reg;
    logic [DPX_W-1:0]  diff_px_reg;
    logic [PX_W-1:0]   res_px_reg;

    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic              s_xfer;
    logic [2:0]        act;
    logic [IDX_W-1:0]  in_idx;
    logic [PX_W-1:0]   in_px;
    logic              in_rng;
    logic              idx_rng;
    logic              last_px;
    logic              out_free;

    logic              tgt_we, cur_we, dif_we;
    logic [AW-1:0]     cur_waddr;
    logic [PX_W-1:0]   cur_wdata;
    logic [PX_W-1:0]   tgt_q, cur_q;
    logic [DPX_W-1:0]  dif_q;
    logic [PX_W-1:0]   tgt_rd, cur_rd;
    logic [DPX_W-1:0]  dif_new;

    rlfe_pkg::scale_req_t req;
    rlfe_pkg::scale_rsp_t rsp;

    // Unpack the input transfer
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign act      = s_tuser;
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_px    = s_tdata[IDX_W +: PX_W];
    assign in_rng   = ({1'b0, in_idx} < (IDX_W + 1)'(PIXELS));
    assign idx_rng  = ({1'b0, idx_reg} < (IDX_W + 1)'(PIXELS));
    assign last_px  = (idx_reg == IDX_W'(PIXELS - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    // Frame RAM write controls
    assign tgt_we    = s_xfer && (act == rlfe_pkg::ACT_SET_TARGET) && in_rng;
    assign cur_we    = (s_xfer && (act == rlfe_pkg::ACT_SET_CURRENT) && in_rng)
                       || ((state_reg == ST_EMIT) && out_free);
    assign cur_waddr = (state_reg == ST_EMIT) ? idx_reg[AW-1:0] : in_idx[AW-1:0];
    assign cur_wdata = (state_reg == ST_EMIT) ? res_px_reg : in_px;
    assign dif_we    = (state_reg == ST_CALC) && start_reg;

    rlfe_ram #(.WIDTH(PX_W), .DEPTH(PIXELS)) u_tgt_ram (
        .aclk  (aclk),
        .we    (tgt_we),
        .waddr (in_idx[AW-1:0]),
        .wdata (in_px),
        .raddr (idx_reg[AW-1:0]),
        .rdata (tgt_q)
    );

    rlfe_ram #(.WIDTH(PX_W), .DEPTH(PIXELS)) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (cur_q)
    );

    rlfe_ram #(.WIDTH(DPX_W), .DEPTH(PIXELS)) u_dif_ram (
        .aclk  (aclk),
        .we    (dif_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (dif_new),
        .raddr (idx_reg[AW-1:0]),
        .rdata (dif_q)
    );

    // Entries never written read as zero
    assign tgt_rd = (idx_rng && tgt_vld_reg[idx_reg[AW-1:0]]) ? tgt_q : '0;
    assign cur_rd = (idx_rng && cur_vld_reg[idx_reg[AW-1:0]]) ? cur_q : '0;

    // Per-channel difference current minus target
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            dif_new[c*DW +: DW] = {1'b0, cur_rd[c*CH_W +: CH_W]}
                                  - {1'b0, tgt_rd[c*CH_W +: CH_W]};
        end
    end

    // Feed one channel per cycle to the scaler
    always_comb begin
        req.vld    = (state_reg == ST_ISSUE);
        req.factor = pass_f_reg;
        req.diff   = diff_px_reg[ch_reg*DW +: DW];
        req.target = tgt_px_reg[ch_reg*CH_W +: CH_W];
        req.ch     = ch_reg;
    end

    rlfe_scale_unit #(.STEPS(STEPS)) u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (act)
                        rlfe_pkg::ACT_START: state_next = ST_READ;
                        rlfe_pkg::ACT_TICK: begin
                            if (fade_active_reg) begin
                                state_next = ST_READ;
                            end
                        end
                        rlfe_pkg::ACT_READ: state_next = ST_RDADDR;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_CALC;
            ST_CALC:   state_next = ST_ISSUE;
            ST_ISSUE: begin
                if (ch_reg == CSEL_W'(NCH - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (rsp.vld && (rsp.ch == CSEL_W'(NCH - 1))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = last_px ? ST_IDLE : ST_READ;
                end
            end
            ST_RDADDR: state_next = ST_RDOUT;
            ST_RDOUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            factor_reg      <= '0;
            fade_active_reg <= 1'b0;
            tgt_vld_reg     <= '0;
            cur_vld_reg     <= '0;
        end else begin
            state_reg <= state_next;

            // Mark written entries
            if (tgt_we) begin
                tgt_vld_reg[in_idx[AW-1:0]] <= 1'b1;
            end
            if (cur_we) begin
                cur_vld_reg[cur_waddr] <= 1'b1;
            end

            // Take a transfer: latch index, step the fade factor at pass start
            if (s_xfer) begin
                case (act)
                    rlfe_pkg::ACT_START: begin
                        idx_reg         <= '0;
                        fade_active_reg <= 1'b1;
                        factor_reg      <= FAC_W'(STEPS - 2);
                    end
                    rlfe_pkg::ACT_TICK: begin
                        idx_reg <= '0;
                        if (fade_active_reg) begin
                            if (factor_reg == '0) begin
                                fade_active_reg <= 1'b0;
                            end else begin
                                factor_reg <= factor_reg - 1'b1;
                            end
                        end
                    end
                    rlfe_pkg::ACT_READ: idx_reg <= in_idx;
                    default: idx_reg <= '0;
                endcase
            end

            // Advance to the next pixel of a pass
            if ((state_reg == ST_EMIT) && out_free && !last_px) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Pass payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            start_reg  <= (act == rlfe_pkg::ACT_START);
            pass_f_reg <= (act == rlfe_pkg::ACT_START) ? FAC_W'(STEPS - 1) : factor_reg;
        end
        if (state_reg == ST_CALC) begin
            tgt_px_reg  <= tgt_rd;
            diff_px_reg <= start_reg ? dif_new : dif_q;
            ch_reg      <= '0;
        end
        if (state_reg == ST_ISSUE) begin
            ch_reg <= ch_reg + 1'b1;
        end
        if (rsp.vld) begin
            res_px_reg[rsp.ch*CH_W +: CH_W] <= rsp.value;
        end
    end

    // Output register: load pass pixels and read results, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT || state_reg == ST_RDOUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            m_tdata_reg <= {2'b00, res_px_reg, idx_reg};
            m_tlast_reg <= last_px;
            m_tuser_reg <= fade_active_reg;
        end else if ((state_reg == ST_RDOUT) && out_free) begin
            m_tdata_reg <= {2'b00, cur_rd, idx_reg};
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= fade_active_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/rlfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rlfe_scale_unit.sv
// Three-stage channel scaler: target + trunc(factor * diff / STEPS), modulo 256.
// Depends on rlfe_pkg for the request and response structs.
module rlfe_scale_unit #(
    parameter int STEPS = 37
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rlfe_pkg::scale_req_t req,
    output rlfe_pkg::scale_rsp_t rsp
);

    // Exact reciprocal for numerators below 2^NUM_W
    localparam int LOG_S = $clog2(STEPS);
    localparam int NUM_W = rlfe_pkg::CH_W + LOG_S;
    localparam int SHIFT = NUM_W + LOG_S;
    localparam int REC_W = NUM_W + 1;
    localparam int unsigned RECIP = ((1 << SHIFT) + STEPS - 1) / STEPS;
    localparam int PROD_W = rlfe_pkg::FAC_W + rlfe_pkg::CH_W;
    localparam int MUL_W  = PROD_W + REC_W;

    logic [rlfe_pkg::DIFF_W-1:0] mag;
    logic [MUL_W-1:0]            q_full;
    logic [rlfe_pkg::CH_W-1:0]   quot;

    logic                        s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [PROD_W-1:0]           s1_prod_reg;
    logic                        s1_neg_reg, s2_neg_reg;
    logic [rlfe_pkg::CH_W-1:0]   s1_tgt_reg, s2_tgt_reg;
    logic [rlfe_pkg::CSEL_W-1:0] s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic [MUL_W-1:0]            s2_mul_reg;
    logic [rlfe_pkg::CH_W-1:0]   s3_val_reg;

    // Magnitude of the signed difference
    assign mag = req.diff[rlfe_pkg::DIFF_W-1] ? (~req.diff + 1'b1) : req.diff;

    // Quotient from the reciprocal product
    assign q_full = s2_mul_reg >> SHIFT;
    assign quot   = q_full[rlfe_pkg::CH_W-1:0];

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= req.vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Stage 1: factor times magnitude; stage 2: times reciprocal;
    // stage 3: apply sign and add target
    always_ff @(posedge aclk) begin
        s1_prod_reg <= req.factor * mag[rlfe_pkg::CH_W-1:0];
        s1_neg_reg  <= req.diff[rlfe_pkg::DIFF_W-1];
        s1_tgt_reg  <= req.target;
        s1_ch_reg   <= req.ch;

        s2_mul_reg  <= MUL_W'(s1_prod_reg) * MUL_W'(REC_W'(RECIP));
        s2_neg_reg  <= s1_neg_reg;
        s2_tgt_reg  <= s1_tgt_reg;
        s2_ch_reg   <= s1_ch_reg;

        s3_val_reg  <= s2_neg_reg ? (s2_tgt_reg - quot) : (s2_tgt_reg + quot);
        s3_ch_reg   <= s2_ch_reg;
    end

    assign rsp.vld   = s3_vld_reg;
    assign rsp.value = s3_val_reg;
    assign rsp.ch    = s3_ch_reg;

endmodule
